// ===== src/fbh_pkg.sv =====
// Package: constants, types and helpers of the fingerprint bucket hash table.
`timescale 1ns / 1ps
package fbh_pkg;
  localparam int NUM_BUCKETS     = 256;
  localparam int BAGS_PER_BUCKET = 4;
  localparam int SLOTS_PER_BAG   = 8;
  localparam int BKT_W      = $clog2(NUM_BUCKETS);
  localparam int BAG_W      = $clog2(BAGS_PER_BUCKET);
  localparam int BAG_CNT_W  = $clog2(BAGS_PER_BUCKET + 1);
  localparam int SLOT_W     = $clog2(SLOTS_PER_BAG);
  localparam int ENT_W      = $clog2(BAGS_PER_BUCKET * SLOTS_PER_BAG + 1);
  localparam int FILLED_W   = $clog2(NUM_BUCKETS + 1);
  localparam int TOTAL_W    = 14;
  localparam int NUM_BAGS   = NUM_BUCKETS * BAGS_PER_BUCKET;
  localparam int NUM_SLOTS  = NUM_BAGS * SLOTS_PER_BAG;
  localparam int BINFO_W    = BAG_CNT_W + ENT_W;
  localparam logic [63:0] MIX_MUL1 = 64'h2127599bf4325c37;
  localparam logic [63:0] MIX_MUL2 = 64'h880355f21e6d1965;
  localparam logic [7:0]  FP_NONE  = 8'hff;
  localparam int FP_SHIFT   = 58;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_FIND    = 2'd1,
    CMD_REPLACE = 2'd2,
    CMD_REMOVE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_FOUND     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_ZERO_KEY  = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SALT     = 2'd0,
    CFG_BKT_LOG2 = 2'd1,
    CFG_FILL_PCT = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE, S_HASH, S_BINFO, S_FPCHK, S_SCAN, S_KEYCHK, S_RESOLVE, S_DONE
  } state_t;

  typedef struct packed {
    logic        done;
    logic [63:0] hash;
  } hash_res_t;

  function automatic logic [7:0] key_fingerprint(input logic [63:0] k);
    logic [7:0] z;
    begin
      z = {2'b00, k[63:FP_SHIFT]};
      if (z == 8'd0) z = k[55:48];
      if (z == 8'd0) z = k[47:40];
      if (z == 8'd0) z = k[39:32];
      if (z == 8'd0) z = FP_NONE;
      return z;
    end
  endfunction

  function automatic logic [SLOT_W-1:0] lowest_slot(input logic [SLOTS_PER_BAG-1:0] v);
    logic [SLOT_W-1:0] r;
    begin
      r = '0;
      for (int i = SLOTS_PER_BAG - 1; i >= 0; i--) begin
        if (v[i]) r = SLOT_W'(i);
      end
      return r;
    end
  endfunction
endpackage

// ===== src/fbh_if.sv =====
// Interfaces: request and response channels of the hash table.
`timescale 1ns / 1ps
interface fbh_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [63:0] key;
  logic [63:0] value_in;
  modport source (output valid, cmd, key, value_in, input ready);
  modport sink (input valid, cmd, key, value_in, output ready);
endinterface

interface fbh_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] value_out;
  logic        split_wanted;
  logic [13:0] entry_count;
  modport source (output valid, status, value_out, split_wanted, entry_count, input ready);
  modport sink (input valid, status, value_out, split_wanted, entry_count, output ready);
endinterface

// ===== src/fbh_ram.sv =====
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module fbh_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/fbh_hash.sv =====
// Salted two-multiply key mix on one shared 32x32 multiplier.
`timescale 1ns / 1ps
module fbh_hash
  import fbh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] key,
  input  logic [63:0] salt,
  output hash_res_t   res
);
  logic [63:0] k_r, a_r, acc_r, acc_nxt, a_nxt;
  logic [1:0]  sub_r;
  logic        phase_r, busy_r, done_r;
  logic [31:0] op_a, op_b;
  logic [63:0] prod, b_sel;

  always_comb begin
    b_sel = phase_r ? MIX_MUL2 : MIX_MUL1;
    op_a  = (sub_r == 2'd2) ? a_r[63:32] : a_r[31:0];
    op_b  = (sub_r == 2'd1) ? b_sel[63:32] : b_sel[31:0];
    prod  = op_a * op_b;
    if (sub_r == 2'd0) begin
      acc_nxt = prod;
    end else begin
      acc_nxt = {acc_r[63:32] + prod[31:0], acc_r[31:0]};
    end
    a_nxt = k_r ^ acc_nxt ^ (acc_nxt >> 47) ^ salt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      sub_r   <= '0;
      phase_r <= 1'b0;
    end else begin
      done_r <= !start && busy_r && (sub_r == 2'd2) && phase_r;
      if (start) begin
        busy_r  <= 1'b1;
        sub_r   <= '0;
        phase_r <= 1'b0;
        k_r     <= key;
        a_r     <= key ^ (key >> 23);
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        if (sub_r == 2'd2) begin
          sub_r <= '0;
          if (phase_r) begin
            busy_r <= 1'b0;
          end else begin
            phase_r <= 1'b1;
            a_r     <= a_nxt;
          end
        end else begin
          sub_r <= sub_r + 2'd1;
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.hash = acc_r;
endmodule

// ===== src/fingerprint_bucket_hash_table_core.sv =====
// Top level: request sequencer of the fingerprint bucket hash table.
`timescale 1ns / 1ps
// One request is taken at a time. A request with a nonzero key is hashed by
// the key mix on one 32x32 multiplier, then scans the bags of its bucket in
// turn through the single read port of the fingerprint memory and reads the
// keys of fingerprint candidates through the single read port of the slot
// memory until one matches. A zero key skips the hash and the table lookup and
// answers with the zero-key status. The result waits in an output register,
// and the next request is accepted as soon as the sequencer is idle again.
// No clearing pass is needed after reset: bucket records carry valid bits,
// and a bag's fingerprint word is written in full when the bag opens.
module fingerprint_bucket_hash_table_core
  import fbh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  fbh_req_if.sink              in_ch,
  fbh_rsp_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_wdata
);
  state_t state_r, state_nxt;

  logic [63:0] salt_r;
  logic [3:0]  bkt_log2_r;
  logic [6:0]  fill_pct_r;

  logic [1:0]  cmd_r;
  logic [63:0] key_r, val_r;
  logic [7:0]  fp_r;
  logic [BKT_W-1:0]     bkt_r, bkt_nxt;
  logic [BAG_CNT_W-1:0] nbags_r, g_r;
  logic [ENT_W-1:0]     nent_r;
  logic [SLOTS_PER_BAG-1:0] cand_r;
  logic [63:0]          cur_fpw_r;
  logic                 free_got_r;
  logic [BAG_W-1:0]     free_bag_r, hit_bag_r;
  logic [SLOT_W-1:0]    free_slot_r, hit_slot_r, cur_slot_r;
  logic [63:0]          free_fpw_r, hit_fpw_r, hit_val_r;
  logic                 hit_r;
  logic [FILLED_W-1:0]  filled_r;
  logic [TOTAL_W-1:0]   total_r;
  logic [2:0]           res_status_r;
  logic [63:0]          res_val_r;
  logic                 res_split_r;

  logic                 out_valid_r;
  logic [2:0]           out_status_r;
  logic [63:0]          out_val_r;
  logic                 out_split_r;
  logic [TOTAL_W-1:0]   out_count_r;

  logic [NUM_BUCKETS-1:0] bvld_r;
  logic                   bvld_rd_r;

  hash_res_t hres;
  logic      hash_start;
  logic [3:0] eff_log2;
  logic [BKT_W-1:0] bkt_mask;

  logic                 binfo_we;
  logic [BKT_W-1:0]     binfo_raddr;
  logic [BINFO_W-1:0]   binfo_wdata, binfo_rdata;
  logic                 fp_we;
  logic [BKT_W+BAG_W-1:0] fp_waddr, fp_raddr;
  logic [63:0]          fp_wdata, fp_rdata;
  logic                 slot_we;
  logic [BKT_W+BAG_W+SLOT_W-1:0] slot_waddr, slot_raddr;
  logic [127:0]         slot_wdata, slot_rdata;

  logic [SLOTS_PER_BAG-1:0] cand_now, free_now;
  logic [BAG_CNT_W-1:0]     g_next;
  logic                     key_hit;
  logic [BAG_CNT_W-1:0]     nbags_cur;
  logic [ENT_W-1:0]         nent_cur;
  logic                     ins_ok;
  logic [BAG_W-1:0]         ins_bag;
  logic [SLOT_W-1:0]        ins_slot;
  logic [FILLED_W-1:0]      filled_inc;
  logic [FILLED_W+6:0]      fill_prod;
  logic [FILLED_W+6:0]      fill_pct;
  logic                     out_free;

  fbh_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (in_ch.key),
    .salt  (salt_r),
    .res   (hres)
  );

  fbh_ram #(.Width(BINFO_W), .Depth(NUM_BUCKETS)) u_binfo_ram (
    .clk (clk), .we (binfo_we), .waddr (bkt_r), .wdata (binfo_wdata),
    .raddr (binfo_raddr), .rdata (binfo_rdata)
  );

  fbh_ram #(.Width(64), .Depth(NUM_BAGS)) u_fp_ram (
    .clk (clk), .we (fp_we), .waddr (fp_waddr), .wdata (fp_wdata),
    .raddr (fp_raddr), .rdata (fp_rdata)
  );

  fbh_ram #(.Width(128), .Depth(NUM_SLOTS)) u_slot_ram (
    .clk (clk), .we (slot_we), .waddr (slot_waddr), .wdata (slot_wdata),
    .raddr (slot_raddr), .rdata (slot_rdata)
  );

  always_comb begin
    eff_log2   = (bkt_log2_r > 4'(BKT_W)) ? 4'(BKT_W) : bkt_log2_r;
    bkt_mask   = ~({BKT_W{1'b1}} << eff_log2);
    bkt_nxt    = hres.hash[BKT_W-1:0] & bkt_mask;
    out_free   = !out_valid_r || out_ch.ready;
    hash_start = in_ch.valid && in_ch.ready && (in_ch.key != 64'd0);
    for (int s = 0; s < SLOTS_PER_BAG; s++) begin
      cand_now[s] = fp_rdata[63-8*s -: 8] == fp_r;
      free_now[s] = fp_rdata[63-8*s -: 8] == 8'd0;
    end
    g_next    = g_r + BAG_CNT_W'(1);
    key_hit   = slot_rdata[127:64] == key_r;
    nbags_cur = bvld_rd_r ? binfo_rdata[BINFO_W-1:ENT_W] : '0;
    nent_cur  = bvld_rd_r ? binfo_rdata[ENT_W-1:0] : '0;
    ins_ok    = free_got_r || (nbags_r < BAG_CNT_W'(BAGS_PER_BUCKET));
    ins_bag   = free_got_r ? free_bag_r : nbags_r[BAG_W-1:0];
    ins_slot  = free_got_r ? free_slot_r : '0;
    filled_inc = filled_r + FILLED_W'(1);
    fill_prod = (FILLED_W+7)'(filled_inc) * (FILLED_W+7)'(100);
    fill_pct  = fill_prod >> eff_log2;
  end

  always_comb begin
    state_nxt   = state_r;
    binfo_raddr = bkt_nxt;
    fp_raddr    = {bkt_r, g_r[BAG_W-1:0]};
    slot_raddr  = {bkt_r, g_r[BAG_W-1:0], lowest_slot(cand_r)};
    binfo_we    = 1'b0;
    binfo_wdata = {nbags_r, nent_r};
    fp_we       = 1'b0;
    fp_waddr    = {bkt_r, ins_bag};
    fp_wdata    = free_fpw_r | ({fp_r, 56'd0} >> {ins_slot, 3'b000});
    slot_we     = 1'b0;
    slot_waddr  = {bkt_r, ins_bag, ins_slot};
    slot_wdata  = {key_r, val_r};
    in_ch.ready = state_r == S_IDLE;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = (in_ch.key == 64'd0) ? S_DONE : S_HASH;
        end
      end
      S_HASH: begin
        if (hres.done) state_nxt = S_BINFO;
      end
      S_BINFO: begin
        fp_raddr  = {bkt_r, {BAG_W{1'b0}}};
        state_nxt = (nbags_cur == '0) ? S_RESOLVE : S_FPCHK;
      end
      S_FPCHK: begin
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        fp_raddr = {bkt_r, g_next[BAG_W-1:0]};
        if (cand_r != '0) begin
          state_nxt = S_KEYCHK;
        end else if (g_next < nbags_r) begin
          state_nxt = S_FPCHK;
        end else begin
          state_nxt = S_RESOLVE;
        end
      end
      S_KEYCHK: begin
        state_nxt = key_hit ? S_RESOLVE : S_SCAN;
      end
      S_RESOLVE: begin
        state_nxt = S_DONE;
        if (hit_r) begin
          slot_waddr = {bkt_r, hit_bag_r, hit_slot_r};
          fp_waddr   = {bkt_r, hit_bag_r};
          fp_wdata   = hit_fpw_r & ~({8'hff, 56'd0} >> {hit_slot_r, 3'b000});
          binfo_wdata = {nbags_r, (nent_r != '0) ? nent_r - ENT_W'(1) : nent_r};
          if (cmd_r == CMD_REPLACE) slot_we = 1'b1;
          if (cmd_r == CMD_REMOVE) begin
            fp_we    = 1'b1;
            binfo_we = 1'b1;
          end
        end else if (cmd_r == CMD_INSERT && ins_ok) begin
          slot_we  = 1'b1;
          fp_we    = 1'b1;
          binfo_we = 1'b1;
          binfo_wdata = {free_got_r ? nbags_r : nbags_r + BAG_CNT_W'(1),
                         nent_r + ENT_W'(1)};
        end
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      salt_r      <= '0;
      bkt_log2_r  <= 4'd8;
      fill_pct_r  <= 7'd75;
      bvld_r      <= '0;
      filled_r    <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SALT:     salt_r     <= cfg_wdata;
          CFG_BKT_LOG2: bkt_log2_r <= cfg_wdata[3:0];
          CFG_FILL_PCT: fill_pct_r <= cfg_wdata[6:0];
          default: ;
        endcase
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (binfo_we) bvld_r[bkt_r] <= 1'b1;
      if (state_r == S_RESOLVE) begin
        if (hit_r && cmd_r == CMD_REMOVE) begin
          if (total_r != '0) total_r <= total_r - TOTAL_W'(1);
          if (nent_r == ENT_W'(1) && filled_r != '0) filled_r <= filled_r - FILLED_W'(1);
        end else if (!hit_r && cmd_r == CMD_INSERT && ins_ok) begin
          total_r <= total_r + TOTAL_W'(1);
          if (nent_r == '0) filled_r <= filled_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    bvld_rd_r <= bvld_r[binfo_raddr];
    case (state_r)
      S_IDLE: begin
        cmd_r        <= in_ch.cmd;
        key_r        <= in_ch.key;
        val_r        <= in_ch.value_in;
        fp_r         <= key_fingerprint(in_ch.key);
        hit_r        <= 1'b0;
        free_got_r   <= 1'b0;
        free_fpw_r   <= '0;
        res_status_r <= ST_ZERO_KEY;
        res_val_r    <= '0;
        res_split_r  <= 1'b0;
      end
      S_HASH: begin
        bkt_r <= bkt_nxt;
      end
      S_BINFO: begin
        nbags_r <= nbags_cur;
        nent_r  <= nent_cur;
        g_r     <= '0;
      end
      S_FPCHK: begin
        cand_r    <= cand_now;
        cur_fpw_r <= fp_rdata;
        if (!free_got_r && free_now != '0) begin
          free_got_r  <= 1'b1;
          free_bag_r  <= g_r[BAG_W-1:0];
          free_slot_r <= lowest_slot(free_now);
          free_fpw_r  <= fp_rdata;
        end
      end
      S_SCAN: begin
        if (cand_r != '0) begin
          cur_slot_r <= lowest_slot(cand_r);
          cand_r[lowest_slot(cand_r)] <= 1'b0;
        end else begin
          g_r <= g_next;
        end
      end
      S_KEYCHK: begin
        if (key_hit) begin
          hit_r      <= 1'b1;
          hit_bag_r  <= g_r[BAG_W-1:0];
          hit_slot_r <= cur_slot_r;
          hit_fpw_r  <= cur_fpw_r;
          hit_val_r  <= slot_rdata[63:0];
        end
      end
      S_RESOLVE: begin
        res_val_r   <= (hit_r && cmd_r != CMD_REPLACE) ? hit_val_r : '0;
        res_split_r <= !hit_r && (cmd_r == CMD_INSERT) && ins_ok && (nent_r == '0) &&
                       (fill_pct > (FILLED_W+7)'(fill_pct_r));
        if (hit_r) begin
          res_status_r <= ST_FOUND;
        end else if (cmd_r != CMD_INSERT) begin
          res_status_r <= ST_NOT_FOUND;
        end else if (!ins_ok) begin
          res_status_r <= ST_FULL;
        end else begin
          res_status_r <= ST_INSERTED;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_status_r <= res_status_r;
          out_val_r    <= res_val_r;
          out_split_r  <= res_split_r;
          out_count_r  <= total_r;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.value_out    = out_val_r;
  assign out_ch.split_wanted = out_split_r;
  assign out_ch.entry_count  = out_count_r;
endmodule
